>>> rtl/core/hrlp_pkg.sv
package hrlp_pkg;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       restart;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] path_byte;
        logic [1:0] method_code;
        logic [1:0] version_code;
    } t_out_beat;

    localparam logic [1:0] KIND_PATH   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_BAD    = 2'd2;

    localparam logic [1:0] METHOD_GET    = 2'd0;
    localparam logic [1:0] METHOD_POST   = 2'd1;
    localparam logic [1:0] METHOD_DELETE = 2'd2;

    localparam logic [1:0] VERSION_0_9 = 2'd0;
    localparam logic [1:0] VERSION_1_0 = 2'd1;
    localparam logic [1:0] VERSION_1_1 = 2'd2;

    typedef enum logic [15:0] {
        PH_START = 16'h0001,
        PH_METHOD = 16'h0002,
        PH_SLASH = 16'h0004,
        PH_PATH = 16'h0008,
        PH_H = 16'h0010,
        PH_T1 = 16'h0020,
        PH_T2 = 16'h0040,
        PH_P = 16'h0080,
        PH_SEP = 16'h0100,
        PH_HBAD = 16'h0200,
        PH_MAJOR = 16'h0400,
        PH_DOT = 16'h0800,
        PH_MINOR = 16'h1000,
        PH_CR = 16'h2000,
        PH_LF = 16'h4000,
        PH_DONE = 16'h8000
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] method_length;
        logic [2:0] method_match_flags;
        logic [1:0] method_found;
        logic [3:0] major_digit;
        logic [1:0] version_found;
    } t_parse_state;

    localparam t_parse_state STATE_RESET = '{
        phase: PH_START,
        method_length: 3'd0,
        method_match_flags: 3'b111,
        method_found: 2'd0,
        major_digit: 4'd0,
        version_found: 2'd0
    };

endpackage

>>> rtl/core/hrlp_step.sv
module hrlp_step
    import hrlp_pkg::*;
(
    input  t_parse_state i_state,
    input  t_in_beat     i_beat,
    output t_parse_state o_state,
    output logic         o_res_valid,
    output t_out_beat    o_res
);

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5a;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    function automatic logic [7:0] get_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h45;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] post_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h50;
            3'd1:    c = 8'h4f;
            3'd2:    c = 8'h53;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] delete_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h44;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h4c;
            3'd3:    c = 8'h45;
            3'd4:    c = 8'h54;
            default: c = 8'h45;
        endcase
        return c;
    endfunction

    t_parse_state s;
    logic [7:0]   b;
    logic [2:0]   fed_flags;
    logic [2:0]   fed_len;
    logic         is_digit;
    logic [3:0]   digit;

    assign s        = i_beat.restart ? STATE_RESET : i_state;
    assign b        = i_beat.line_byte;
    assign is_digit = (b >= CH_0) && (b <= CH_9);
    assign digit    = 4'(b - CH_0);

    always_comb begin
        fed_flags = s.method_match_flags;
        if (s.method_length >= 3'd3 || b != get_char(s.method_length)) begin
            fed_flags[0] = 1'b0;
        end
        if (s.method_length >= 3'd4 || b != post_char(s.method_length)) begin
            fed_flags[1] = 1'b0;
        end
        if (s.method_length >= 3'd6 || b != delete_char(s.method_length)) begin
            fed_flags[2] = 1'b0;
        end
        fed_len = (s.method_length == 3'd7) ? 3'd7 : s.method_length + 3'd1;
    end

    always_comb begin
        logic bad;
        bad         = 1'b0;
        o_state     = s;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (s.phase)
            PH_START: begin
                if (b != CH_CR && b != CH_LF) begin
                    if (b < CH_A || b > CH_Z) begin
                        bad = 1'b1;
                    end else begin
                        o_state.method_match_flags = fed_flags;
                        o_state.method_length      = fed_len;
                        o_state.phase              = PH_METHOD;
                    end
                end
            end
            PH_METHOD: begin
                if (b != CH_SP) begin
                    o_state.method_match_flags = fed_flags;
                    o_state.method_length      = fed_len;
                end else begin
                    priority if (s.method_match_flags[0] && s.method_length == 3'd3) begin
                        o_state.method_found = METHOD_GET;
                        o_state.phase        = PH_SLASH;
                    end else if (s.method_match_flags[1] && s.method_length == 3'd4) begin
                        o_state.method_found = METHOD_POST;
                        o_state.phase        = PH_SLASH;
                    end else if (s.method_match_flags[2] && s.method_length == 3'd6) begin
                        o_state.method_found = METHOD_DELETE;
                        o_state.phase        = PH_SLASH;
                    end else begin
                        bad = 1'b1;
                    end
                end
            end
            PH_SLASH: begin
                if (b != CH_SLASH) begin
                    bad = 1'b1;
                end else begin
                    o_state.phase   = PH_PATH;
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_PATH;
                    o_res.path_byte = b;
                end
            end
            PH_PATH: begin
                if (b == CH_SP) begin
                    o_state.phase = PH_H;
                end else begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_PATH;
                    o_res.path_byte = b;
                end
            end
            PH_H: begin
                if (b != CH_H) begin
                    bad = 1'b1;
                end else begin
                    o_state.phase = PH_T1;
                end
            end
            PH_T1, PH_T2, PH_P, PH_SEP, PH_HBAD: begin
                priority if (s.phase == PH_T1 && b == CH_T) begin
                    o_state.phase = PH_T2;
                end else if (s.phase == PH_T2 && b == CH_T) begin
                    o_state.phase = PH_P;
                end else if (s.phase == PH_P && b == CH_P) begin
                    o_state.phase = PH_SEP;
                end else if (s.phase == PH_SEP && b == CH_SLASH) begin
                    o_state.phase = PH_MAJOR;
                end else if (b == CH_T || b == CH_P) begin
                    o_state.phase = PH_HBAD;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_MAJOR: begin
                if (!is_digit) begin
                    bad = 1'b1;
                end else begin
                    o_state.major_digit = digit;
                    o_state.phase       = PH_DOT;
                end
            end
            PH_DOT: begin
                if (b != CH_DOT) begin
                    bad = 1'b1;
                end else begin
                    o_state.phase = PH_MINOR;
                end
            end
            PH_MINOR: begin
                priority if (!is_digit) begin
                    bad = 1'b1;
                end else if (s.major_digit == 4'd0 && digit == 4'd9) begin
                    o_state.version_found = VERSION_0_9;
                    o_state.phase         = PH_CR;
                end else if (s.major_digit == 4'd1 && digit == 4'd0) begin
                    o_state.version_found = VERSION_1_0;
                    o_state.phase         = PH_CR;
                end else if (s.major_digit == 4'd1 && digit == 4'd1) begin
                    o_state.version_found = VERSION_1_1;
                    o_state.phase         = PH_CR;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_CR: begin
                if (b != CH_CR) begin
                    bad = 1'b1;
                end else begin
                    o_state.phase = PH_LF;
                end
            end
            PH_LF: begin
                if (b != CH_LF) begin
                    bad = 1'b1;
                end else begin
                    o_state.phase      = PH_DONE;
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_ACCEPT;
                    o_res.method_code  = s.method_found;
                    o_res.version_code = s.version_found;
                end
            end
            PH_DONE: begin
                o_state = s;
            end
            default: begin
                o_state = s;
            end
        endcase
        if (bad) begin
            o_state.phase = PH_DONE;
            o_res_valid   = 1'b1;
            o_res         = '0;
            o_res.kind    = KIND_BAD;
        end
    end

endmodule

>>> rtl/core/hrlp_out_buf.sv
module hrlp_out_buf
    import hrlp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_beat i_beat,
    input  logic      i_out_stall,
    output logic      o_free,
    output logic      o_out_valid,
    output t_out_beat o_out_beat
);

    logic      r_valid;
    t_out_beat r_beat;

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

endmodule

>>> rtl/core/http_request_line_parser.sv
// channel | valid      | stall       | beat
// input   | i_in_valid | o_in_stall  | i_in_beat  (line_byte, restart)
// output  | o_out_valid| i_out_stall | o_out_beat (kind, path_byte, method_code, version_code)
//
// one byte per cycle while the output is not stalled
// the input register feeds the per-byte phase update, which writes the output register
// i_rst_n low for one clock returns the parser to line start and empties both registers
// a stalled output holds its beat; the input stalls only while the input register is
// full and the output register can neither drain nor take a new result
module http_request_line_parser
    import hrlp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    logic         r_in_valid;
    t_in_beat     r_in_beat;
    t_parse_state r_state;
    t_parse_state n_state;
    logic         res_valid;
    t_out_beat    res_beat;
    logic         out_free;
    logic         advance;

    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_beat <= i_in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    hrlp_step u_step (
        .i_state    (r_state),
        .i_beat     (r_in_beat),
        .o_state    (n_state),
        .o_res_valid(res_valid),
        .o_res      (res_beat)
    );

    hrlp_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && res_valid),
        .i_beat     (res_beat),
        .i_out_stall(i_out_stall),
        .o_free     (out_free),
        .o_out_valid(o_out_valid),
        .o_out_beat (o_out_beat)
    );

endmodule

>>> rtl/core/hrlp_checker.sv
module hrlp_assertions
    import hrlp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_beat
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled output beat changed");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output can drain");

    a_path_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.kind != KIND_PATH |-> o_out_beat.path_byte == 8'd0)
        else $error("path byte set on non-path result");

    a_codes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.kind != KIND_ACCEPT
            |-> o_out_beat.method_code == 2'd0 && o_out_beat.version_code == 2'd0)
        else $error("codes set on non-accept result");

    a_accept_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.kind == KIND_ACCEPT
            |-> o_out_beat.method_code != 2'd3 && o_out_beat.version_code != 2'd3)
        else $error("accept result with illegal code");

endmodule

bind http_request_line_parser hrlp_assertions u_hrlp_assertions (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_beat (o_out_beat)
);

>>> tb/hrlp_checker.sv
module hrlp_checker
    import hrlp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_beat,
    input  logic      i_run_done,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_live_bytes,
    output int        o_path_count,
    output int        o_accept_count,
    output int        o_bad_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] CH_P       = 8'h50;

    localparam logic [23:0] NAME_GET    = "GET";
    localparam logic [31:0] NAME_POST   = "POST";
    localparam logic [47:0] NAME_DELETE = "DELETE";

    // predictor state
    t_phase     parser_phase;
    logic [2:0] method_len;
    logic [2:0] method_flags;
    logic [1:0] found_method;
    logic [3:0] major_digit;
    logic [1:0] found_version;

    t_out_beat expected_q[$];
    int        fail_count   = 0;
    int        live_bytes   = 0;
    int        path_count   = 0;
    int        accept_count = 0;
    int        bad_count    = 0;
    logic      run_checked  = 1'b0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic clear_parser();
        parser_phase  = PH_START;
        method_len    = 3'd0;
        method_flags  = 3'b111;
        found_method  = METHOD_GET;
        major_digit   = 4'd0;
        found_version = VERSION_0_9;
    endtask

    task automatic take_method_byte(input logic [7:0] b);
        int n;
        n = method_len;
        if (n >= 3) method_flags[0] = 1'b0;
        else if (b != NAME_GET[8*(2-n) +: 8]) method_flags[0] = 1'b0;
        if (n >= 4) method_flags[1] = 1'b0;
        else if (b != NAME_POST[8*(3-n) +: 8]) method_flags[1] = 1'b0;
        if (n >= 6) method_flags[2] = 1'b0;
        else if (b != NAME_DELETE[8*(5-n) +: 8]) method_flags[2] = 1'b0;
        if (method_len != 3'd7) method_len = method_len + 3'd1;
    endtask

    task automatic parse_byte(input t_in_beat beat, output logic got, output t_out_beat res);
        logic [7:0] b;
        logic       bad;
        logic       is_digit;
        b        = beat.line_byte;
        bad      = 1'b0;
        got      = 1'b0;
        res      = '0;
        is_digit = (b >= CH_ZERO && b <= CH_NINE);
        if (beat.restart) clear_parser();
        case (parser_phase)
            PH_START: begin
                if (b != CH_CR && b != CH_LF) begin
                    if (b < CH_UPPER_A || b > CH_UPPER_Z) begin
                        bad = 1'b1;
                    end else begin
                        take_method_byte(b);
                        parser_phase = PH_METHOD;
                    end
                end
            end
            PH_METHOD: begin
                if (b != CH_SPACE) begin
                    take_method_byte(b);
                end else if (method_flags[0] && method_len == 3'd3) begin
                    found_method = METHOD_GET;
                    parser_phase = PH_SLASH;
                end else if (method_flags[1] && method_len == 3'd4) begin
                    found_method = METHOD_POST;
                    parser_phase = PH_SLASH;
                end else if (method_flags[2] && method_len == 3'd6) begin
                    found_method = METHOD_DELETE;
                    parser_phase = PH_SLASH;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_SLASH: begin
                if (b != CH_SLASH) begin
                    bad = 1'b1;
                end else begin
                    parser_phase  = PH_PATH;
                    got           = 1'b1;
                    res.kind      = KIND_PATH;
                    res.path_byte = b;
                end
            end
            PH_PATH: begin
                if (b == CH_SPACE) begin
                    parser_phase = PH_H;
                end else begin
                    got           = 1'b1;
                    res.kind      = KIND_PATH;
                    res.path_byte = b;
                end
            end
            PH_H: begin
                if (b != CH_H) bad = 1'b1;
                else parser_phase = PH_T1;
            end
            PH_T1, PH_T2, PH_P, PH_SEP, PH_HBAD: begin
                if (parser_phase == PH_T1 && b == CH_T) parser_phase = PH_T2;
                else if (parser_phase == PH_T2 && b == CH_T) parser_phase = PH_P;
                else if (parser_phase == PH_P && b == CH_P) parser_phase = PH_SEP;
                else if (parser_phase == PH_SEP && b == CH_SLASH) parser_phase = PH_MAJOR;
                else if (b == CH_T || b == CH_P) parser_phase = PH_HBAD;
                else bad = 1'b1;
            end
            PH_MAJOR: begin
                if (!is_digit) begin
                    bad = 1'b1;
                end else begin
                    major_digit  = b[3:0];
                    parser_phase = PH_DOT;
                end
            end
            PH_DOT: begin
                if (b != CH_DOT) bad = 1'b1;
                else parser_phase = PH_MINOR;
            end
            PH_MINOR: begin
                if (!is_digit) begin
                    bad = 1'b1;
                end else if (major_digit == 4'd0 && b[3:0] == 4'd9) begin
                    found_version = VERSION_0_9;
                    parser_phase  = PH_CR;
                end else if (major_digit == 4'd1 && b[3:0] == 4'd0) begin
                    found_version = VERSION_1_0;
                    parser_phase  = PH_CR;
                end else if (major_digit == 4'd1 && b[3:0] == 4'd1) begin
                    found_version = VERSION_1_1;
                    parser_phase  = PH_CR;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_CR: begin
                if (b != CH_CR) bad = 1'b1;
                else parser_phase = PH_LF;
            end
            PH_LF: begin
                if (b != CH_LF) begin
                    bad = 1'b1;
                end else begin
                    parser_phase     = PH_DONE;
                    got              = 1'b1;
                    res.kind         = KIND_ACCEPT;
                    res.method_code  = found_method;
                    res.version_code = found_version;
                end
            end
            default: begin
                // sticky until restart
            end
        endcase
        if (bad) begin
            parser_phase = PH_DONE;
            got          = 1'b1;
            res          = '0;
            res.kind     = KIND_BAD;
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic      got;
        t_out_beat want;
        t_out_beat seen;
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (parser_phase != PH_DONE || i_in_beat.restart) live_bytes++;
                parse_byte(i_in_beat, got, want);
                if (got) expected_q.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                seen = i_out_beat;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result kind %0d with nothing expected",
                                              seen.kind));
                end else begin
                    want = expected_q.pop_front();
                    if (seen.kind != want.kind)
                        report_mismatch($sformatf("kind got %0d expected %0d",
                                                  seen.kind, want.kind));
                    if (seen.path_byte != want.path_byte)
                        report_mismatch($sformatf("path_byte got %02h expected %02h",
                                                  seen.path_byte, want.path_byte));
                    if (seen.method_code != want.method_code)
                        report_mismatch($sformatf("method_code got %0d expected %0d",
                                                  seen.method_code, want.method_code));
                    if (seen.version_code != want.version_code)
                        report_mismatch($sformatf("version_code got %0d expected %0d",
                                                  seen.version_code, want.version_code));
                    case (want.kind)
                        KIND_PATH:   path_count++;
                        KIND_ACCEPT: accept_count++;
                        default:     bad_count++;
                    endcase
                end
            end
            if (i_run_done && !run_checked) begin
                run_checked = 1'b1;
                if (expected_q.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
            end
        end
        o_fail_count   <= fail_count;
        o_pending      <= expected_q.size();
        o_live_bytes   <= live_bytes;
        o_path_count   <= path_count;
        o_accept_count <= accept_count;
        o_bad_count    <= bad_count;
    end

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hrlp_pkg::*;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;

    localparam int ITEM_TARGET = 1550;
    localparam int QUIET_FROM  = 1350;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;
    logic      run_done  = 1'b0;
    logic      quiet     = 1'b0;
    int        stall_pct = 0;
    int        stall_left = 0;
    int        idle_pct  = 0;
    int        lines_sent = 0;
    int        beats_sent = 0;

    int fail_count;
    int pending;
    int live_bytes;
    int path_count;
    int accept_count;
    int bad_count;

    logic [7:0] line_q[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    http_request_line_parser u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    hrlp_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_beat      (in_beat),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_beat     (out_beat),
        .i_run_done     (run_done),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_live_bytes   (live_bytes),
        .o_path_count   (path_count),
        .o_accept_count (accept_count),
        .o_bad_count    (bad_count)
    );

    // result side back-pressure in bursts of random length
    always @(posedge clk) begin
        if (!rst_n || quiet) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endtask

    task automatic send_beat(input t_in_beat beat);
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_line(input logic force_restart);
        t_in_beat beat;
        for (int i = 0; i < line_q.size(); i++) begin
            beat.line_byte = line_q[i];
            if (i == 0) beat.restart = force_restart || ($urandom_range(0, 19) != 0);
            else beat.restart = ($urandom_range(0, 99) == 0);
            send_beat(beat);
        end
        lines_sent++;
    endtask

    task automatic build_request_line();
        int         n;
        int         pick;
        int         pos;
        logic [7:0] b;
        string      near_miss = " /.HTPGEOSDL019";
        line_q.delete();
        // pure noise now and then
        if ($urandom_range(0, 99) < 5) begin
            repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) line_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            case ($urandom_range(0, 2))
                0:       push_text("GET");
                1:       push_text("POST");
                default: push_text("DELETE");
            endcase
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 9)) line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end else begin
            case ($urandom_range(0, 2))
                0:       push_text("GET");
                1:       push_text("POST");
                default: push_text("DELETE");
            endcase
            if ($urandom_range(0, 1)) void'(line_q.pop_back());
            else line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
        line_q.push_back(CH_SPACE);
        line_q.push_back(CH_SLASH);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE);
            line_q.push_back(b);
        end
        line_q.push_back(CH_SPACE);
        if ($urandom_range(0, 99) < 88) begin
            push_text("HTTP/");
        end else begin
            line_q.push_back(CH_H);
            repeat ($urandom_range(0, 5)) line_q.push_back($urandom_range(0, 1) ? CH_T : CH_P);
            if ($urandom_range(0, 9) < 7) line_q.push_back(CH_SLASH);
            else line_q.push_back(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            case ($urandom_range(0, 2))
                0:       push_text("0.9");
                1:       push_text("1.0");
                default: push_text("1.1");
            endcase
        end else begin
            line_q.push_back(8'($urandom_range(8'h30, 8'h39)));
            if (pick < 95) line_q.push_back(CH_DOT);
            else line_q.push_back(8'($urandom_range(0, 255)));
            line_q.push_back(8'($urandom_range(8'h30, 8'h39)));
        end
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
        // broken lines: one byte changed, dropped, or an early end
        pick = $urandom_range(0, 99);
        pos  = $urandom_range(0, line_q.size() - 1);
        if (pick < 10) begin
            line_q[pos] = 8'($urandom_range(0, 255));
        end else if (pick < 20) begin
            if ($urandom_range(0, 3) == 0) line_q[pos] = $urandom_range(0, 1) ? CH_CR : CH_LF;
            else line_q[pos] = near_miss[$urandom_range(0, near_miss.len() - 1)];
        end else if (pick < 25) begin
            line_q.delete(pos);
        end else if (pick < 32) begin
            while (line_q.size() > pos) void'(line_q.pop_back());
            if (line_q.size() == 0) line_q.push_back(CH_CR);
        end
    endtask

    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // accepted line with leading CR LF and extreme path bytes
        line_q.delete();
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
        push_text("DELETE /");
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
        push_text(" HTTP/0.9");
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
        send_line(1'b1);
        // lower-case start
        line_q.delete();
        push_text("g");
        send_line(1'b1);
        // over-long method
        line_q.delete();
        push_text("POSTGET ");
        send_line(1'b1);
        // stray protocol letters
        line_q.delete();
        push_text("GET / HTPTP/");
        send_line(1'b1);
        // unsupported version
        line_q.delete();
        push_text("POST /a HTTP/1.2");
        send_line(1'b1);
        line_q.delete();
        push_text("GET / HTTP/1.1");
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
        send_line(1'b1);

        while (beats_sent < ITEM_TARGET) begin
            if (beats_sent >= QUIET_FROM) quiet <= 1'b1;
            case ($urandom_range(0, 3))
                0: begin
                    idle_pct  = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct  = 10;
                    stall_pct <= 10;
                end
                2: begin
                    idle_pct  = 30;
                    stall_pct <= 30;
                end
                default: begin
                    idle_pct  = 5;
                    stall_pct <= 40;
                end
            endcase
            build_request_line();
            send_line(1'b0);
        end
        in_valid <= 1'b0;

        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (8) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);

        $display("sent %0d request lines in %0d bytes, %0d of them reached the parser",
                 lines_sent, beats_sent, live_bytes);
        $display("checked %0d path bytes, %0d accepted lines, %0d bad requests",
                 path_count, accept_count, bad_count);
        if (fail_count == 0) begin
            $display("PASS http_request_line_parser");
        end else begin
            $display("FAIL http_request_line_parser");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("timeout waiting for the parser");
        $display("FAIL http_request_line_parser");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/hrlp_pkg.sv
rtl/core/hrlp_step.sv
rtl/core/hrlp_out_buf.sv
rtl/core/http_request_line_parser.sv
rtl/core/hrlp_checker.sv
tb/hrlp_checker.sv
tb/testbench.sv
